>>> design/tmf_pkg.sv
package tmf_pkg;

   // Field widths.
   localparam int RAW_W      = 16;
   localparam int SAMPLE_W   = 12;
   localparam int SAMPLE_LSB = 3;
   localparam int COORD_W    = 10;
   localparam int GAIN_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = SAMPLE_W + GAIN_W;

   // Configuration port.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Register reset values.
   localparam logic [SAMPLE_W-1:0] SPREAD_LIMIT_RST = 12'd50;
   localparam logic [SAMPLE_W-1:0] X_MINIMUM_RST    = 12'd120;
   localparam logic [SAMPLE_W-1:0] Y_MINIMUM_RST    = 12'd200;
   localparam logic [COORD_W-1:0]  X_SIZE_RST       = 10'd240;
   localparam logic [COORD_W-1:0]  Y_SIZE_RST       = 10'd320;
   localparam logic [GAIN_W-1:0]   X_GAIN_RST       = 16'd4054;
   localparam logic [GAIN_W-1:0]   Y_GAIN_RST       = 16'd5519;

   typedef enum logic [2:0] {
      REG_SPREAD_LIMIT = 3'd0,
      REG_X_MINIMUM    = 3'd1,
      REG_Y_MINIMUM    = 3'd2,
      REG_X_SIZE       = 3'd3,
      REG_Y_SIZE       = 3'd4,
      REG_X_GAIN       = 3'd5,
      REG_Y_GAIN       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      XS_NONE = 2'd0,
      XS_OK   = 2'd1,
      XS_BAD  = 2'd2
   } x_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_SELECT,
      ST_EVAL,
      ST_MULX,
      ST_MULY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] spread_limit;
      logic [SAMPLE_W-1:0] x_minimum;
      logic [SAMPLE_W-1:0] y_minimum;
      logic [COORD_W-1:0]  x_size;
      logic [COORD_W-1:0]  y_size;
      logic [GAIN_W-1:0]   x_gain;
      logic [GAIN_W-1:0]   y_gain;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rank;
      logic select;
      logic eval;
      logic mulx;
      logic muly;
      logic load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic group_axis;
   } status_type;

endpackage

>>> design/touch_median_filter_to_coordinates.sv
// Touch filter: turns raw converter words into screen coordinates.
// Input channel (req_): each word carries an axis tag (0 X, 1 Y) and the raw
// 16-bit converter word; the 12-bit sample is bits 14..3. A word is accepted
// at a clock edge where req_valid is high and req_stall is low.
// The block gathers a group of SAMPLES_PER_AXIS X samples, then a group of Y
// samples; a sample on the other axis restarts the group. Each group is
// ranked and its median taken. A word that does not end a group leaves
// req_stall low. A word that ends an X group holds req_stall high through
// the rank, select and evaluate steps. A word that ends a Y group also holds
// it through the X and Y scaling steps, since one product register scales X
// and then Y, and through the finish step that loads the result word for rsp_.
// One result word carries both coordinates and a fault flag; both coordinates
// read zero when fault is set (spread too wide, median too low, or no good X
// group since the last result). While rsp_stall holds a result, the block
// keeps taking input words and only waits when the next result is ready.
// Registers sit on an APB-style port, one per 4-byte address. Reset loads
// their default values, empties the group and forgets any held X group.
module touch_median_filter_to_coordinates #(
   parameter int SAMPLES_PER_AXIS = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_axis,
   input  logic [tmf_pkg::RAW_W-1:0]         req_raw_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tmf_pkg::COORD_W-1:0]       rsp_x_coord,
   output logic [tmf_pkg::COORD_W-1:0]       rsp_y_coord,
   output logic                              rsp_fault,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tmf_pkg::ADDR_W-1:0]        paddr,
   input  logic [tmf_pkg::DATA_W-1:0]        pwdata,
   output logic [tmf_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   tmf_pkg::cfg_type    cfg;
   tmf_pkg::cmd_type    cmd;
   tmf_pkg::status_type status;

   // Register file on the configuration port.
   tmf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller sequences one group at a time and owns both handshakes.
   tmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Sample store, ranking, checks, scaling and the output register.
   tmf_datapath #(
      .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .req_axis     (req_axis),
      .req_raw_word (req_raw_word),
      .rsp_x_coord  (rsp_x_coord),
      .rsp_y_coord  (rsp_y_coord),
      .rsp_fault    (rsp_fault)
   );

endmodule

>>> design/tmf_csr.sv
module tmf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tmf_pkg::ADDR_W-1:0]  paddr,
   input  logic [tmf_pkg::DATA_W-1:0]  pwdata,
   output logic [tmf_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output tmf_pkg::cfg_type            cfg
);

   tmf_pkg::cfg_type       cfg_ff;
   tmf_pkg::cfg_type       cfg_in;
   tmf_pkg::csr_index_type index;
   logic                   write;

   assign index  = tmf_pkg::csr_index_type'(paddr[tmf_pkg::ADDR_W-1:2]);
   assign write  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            tmf_pkg::REG_SPREAD_LIMIT: cfg_in.spread_limit = pwdata[tmf_pkg::SAMPLE_W-1:0];
            tmf_pkg::REG_X_MINIMUM:    cfg_in.x_minimum    = pwdata[tmf_pkg::SAMPLE_W-1:0];
            tmf_pkg::REG_Y_MINIMUM:    cfg_in.y_minimum    = pwdata[tmf_pkg::SAMPLE_W-1:0];
            tmf_pkg::REG_X_SIZE:       cfg_in.x_size       = pwdata[tmf_pkg::COORD_W-1:0];
            tmf_pkg::REG_Y_SIZE:       cfg_in.y_size       = pwdata[tmf_pkg::COORD_W-1:0];
            tmf_pkg::REG_X_GAIN:       cfg_in.x_gain       = pwdata[tmf_pkg::GAIN_W-1:0];
            tmf_pkg::REG_Y_GAIN:       cfg_in.y_gain       = pwdata[tmf_pkg::GAIN_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         tmf_pkg::REG_SPREAD_LIMIT: prdata[tmf_pkg::SAMPLE_W-1:0] = cfg_ff.spread_limit;
         tmf_pkg::REG_X_MINIMUM:    prdata[tmf_pkg::SAMPLE_W-1:0] = cfg_ff.x_minimum;
         tmf_pkg::REG_Y_MINIMUM:    prdata[tmf_pkg::SAMPLE_W-1:0] = cfg_ff.y_minimum;
         tmf_pkg::REG_X_SIZE:       prdata[tmf_pkg::COORD_W-1:0]  = cfg_ff.x_size;
         tmf_pkg::REG_Y_SIZE:       prdata[tmf_pkg::COORD_W-1:0]  = cfg_ff.y_size;
         tmf_pkg::REG_X_GAIN:       prdata[tmf_pkg::GAIN_W-1:0]   = cfg_ff.x_gain;
         tmf_pkg::REG_Y_GAIN:       prdata[tmf_pkg::GAIN_W-1:0]   = cfg_ff.y_gain;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spread_limit <= tmf_pkg::SPREAD_LIMIT_RST;
         cfg_ff.x_minimum    <= tmf_pkg::X_MINIMUM_RST;
         cfg_ff.y_minimum    <= tmf_pkg::Y_MINIMUM_RST;
         cfg_ff.x_size       <= tmf_pkg::X_SIZE_RST;
         cfg_ff.y_size       <= tmf_pkg::Y_SIZE_RST;
         cfg_ff.x_gain       <= tmf_pkg::X_GAIN_RST;
         cfg_ff.y_gain       <= tmf_pkg::Y_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/tmf_ctrl.sv
module tmf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tmf_pkg::status_type  status,
   output tmf_pkg::cmd_type     cmd
);

   tmf_pkg::state_type state_ff;
   tmf_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign req_stall = (state_ff != tmf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         tmf_pkg::ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.last) begin
               state_in = tmf_pkg::ST_RANK;
            end
         end
         tmf_pkg::ST_RANK: begin
            cmd.rank = 1'b1;
            state_in = tmf_pkg::ST_SELECT;
         end
         tmf_pkg::ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = tmf_pkg::ST_EVAL;
         end
         tmf_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.group_axis ? tmf_pkg::ST_MULX : tmf_pkg::ST_IDLE;
         end
         tmf_pkg::ST_MULX: begin
            cmd.mulx = 1'b1;
            state_in = tmf_pkg::ST_MULY;
         end
         tmf_pkg::ST_MULY: begin
            cmd.muly = 1'b1;
            state_in = tmf_pkg::ST_FINISH;
         end
         tmf_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_done_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.last) |=> (state_ff == tmf_pkg::ST_RANK))
      else $error("completed group did not start the sort");

   a_word_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tmf_pkg::ST_FINISH))
      else $error("result word raised outside the finish step");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmf_pkg::ST_FINISH && out_free)
      |=> (state_ff == tmf_pkg::ST_IDLE && rsp_valid_ff))
      else $error("finished result was not loaded into the output register");
`endif

endmodule

>>> design/tmf_datapath.sv
module tmf_datapath #(
   parameter int SAMPLES_PER_AXIS = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tmf_pkg::cfg_type              cfg,
   input  tmf_pkg::cmd_type              cmd,
   output tmf_pkg::status_type           status,
   input  logic                          req_axis,
   input  logic [tmf_pkg::RAW_W-1:0]     req_raw_word,
   output logic [tmf_pkg::COORD_W-1:0]   rsp_x_coord,
   output logic [tmf_pkg::COORD_W-1:0]   rsp_y_coord,
   output logic                          rsp_fault
);

   localparam int IDX_W   = $clog2(SAMPLES_PER_AXIS);
   localparam int MID     = SAMPLES_PER_AXIS / 2;
   localparam int SW      = tmf_pkg::SAMPLE_W;
   localparam int CW      = tmf_pkg::COORD_W;
   localparam int PW      = tmf_pkg::PROD_W;
   localparam int QW      = PW - tmf_pkg::FRAC_W + 1;

   // Ceiling of the Q16 product, subtracted from the screen extent with a floor at zero.
   function automatic logic [CW-1:0] to_coord(input logic [PW-1:0] prod,
                                              input logic [CW-1:0] size);
      logic [PW:0]   sum;
      logic [QW-1:0] q;
      begin
         sum = {1'b0, prod} + (PW+1)'({tmf_pkg::FRAC_W{1'b1}});
         q   = sum[PW:tmf_pkg::FRAC_W];
         if (QW'(size) > q) begin
            to_coord = size - q[CW-1:0];
         end else begin
            to_coord = '0;
         end
      end
   endfunction

   logic [SW-1:0]    store_ff [SAMPLES_PER_AXIS];
   logic [IDX_W-1:0] rank_ff  [SAMPLES_PER_AXIS];
   logic [IDX_W-1:0] rank_in  [SAMPLES_PER_AXIS];
   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] wr_idx;
   logic             group_axis_ff;
   logic [SW-1:0]    held_med_ff;
   tmf_pkg::x_status_type held_status_ff;
   logic [SW-1:0]    median_ff;
   logic [SW-1:0]    median_in;
   logic [SW-1:0]    min_val;
   logic [SW-1:0]    max_val;
   logic             spread_bad_ff;
   logic             fault_ff;
   logic [PW-1:0]    prod_ff;
   logic [CW-1:0]    x_coord_ff;
   logic [CW-1:0]    rsp_x_ff;
   logic [CW-1:0]    rsp_y_ff;
   logic             rsp_fault_ff;
   logic [SW-1:0]    minimum;
   logic             low;
   logic [SW-1:0]    diff_x;
   logic [SW-1:0]    diff_y;
   logic             x_below;

   assign wr_idx = (req_axis != group_axis_ff) ? '0 : count_ff;
   assign status.last       = (wr_idx == IDX_W'(SAMPLES_PER_AXIS - 1));
   assign status.group_axis = group_axis_ff;

   // Rank of each sample in the group; equal values are ordered by position.
   always_comb begin
      for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
         rank_in[i] = '0;
         for (int j = 0; j < SAMPLES_PER_AXIS; j++) begin
            if (j != i) begin
               if ((store_ff[j] < store_ff[i]) || ((store_ff[j] == store_ff[i]) && (j < i))) begin
                  rank_in[i] = rank_in[i] + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      median_in = '0;
      min_val   = '0;
      max_val   = '0;
      for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
         if (rank_ff[i] == IDX_W'(MID)) begin
            median_in = median_in | store_ff[i];
         end
         if (rank_ff[i] == '0) begin
            min_val = min_val | store_ff[i];
         end
         if (rank_ff[i] == IDX_W'(SAMPLES_PER_AXIS - 1)) begin
            max_val = max_val | store_ff[i];
         end
      end
   end

   assign minimum = group_axis_ff ? cfg.y_minimum : cfg.x_minimum;
   assign low     = (median_ff < minimum);
   assign diff_x  = held_med_ff - cfg.x_minimum;
   assign diff_y  = median_ff - cfg.y_minimum;
   // The X minimum may have been raised after the held X group was judged.
   // The offset then wraps; unless the gain is zero, the product is forced to
   // its largest value, which scales past any extent.
   assign x_below = (held_med_ff < cfg.x_minimum);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         group_axis_ff  <= 1'b0;
         held_med_ff    <= '0;
         held_status_ff <= tmf_pkg::XS_NONE;
      end else begin
         if (cmd.accept) begin
            count_ff      <= status.last ? '0 : wr_idx + 1'b1;
            group_axis_ff <= req_axis;
         end
         if (cmd.eval) begin
            if (!group_axis_ff) begin
               held_med_ff    <= median_ff;
               held_status_ff <= (spread_bad_ff || low) ? tmf_pkg::XS_BAD : tmf_pkg::XS_OK;
            end else begin
               held_status_ff <= tmf_pkg::XS_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_ff[wr_idx] <= req_raw_word[tmf_pkg::SAMPLE_LSB+SW-1:tmf_pkg::SAMPLE_LSB];
      end
      if (cmd.rank) begin
         rank_ff <= rank_in;
      end
      if (cmd.select) begin
         median_ff     <= median_in;
         spread_bad_ff <= (max_val - min_val) > cfg.spread_limit;
      end
      if (cmd.eval) begin
         fault_ff <= (held_status_ff != tmf_pkg::XS_OK) || spread_bad_ff || low;
      end
      if (cmd.mulx) begin
         prod_ff <= (x_below && (cfg.x_gain != '0)) ? '1 : PW'(diff_x) * PW'(cfg.x_gain);
      end
      if (cmd.muly) begin
         x_coord_ff <= to_coord(prod_ff, cfg.x_size);
         prod_ff    <= PW'(diff_y) * PW'(cfg.y_gain);
      end
      if (cmd.load) begin
         rsp_x_ff     <= fault_ff ? '0 : x_coord_ff;
         rsp_y_ff     <= fault_ff ? '0 : to_coord(prod_ff, cfg.y_size);
         rsp_fault_ff <= fault_ff;
      end
   end

   assign rsp_x_coord = rsp_x_ff;
   assign rsp_y_coord = rsp_y_ff;
   assign rsp_fault   = rsp_fault_ff;

`ifndef ASSERT_OFF
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(SAMPLES_PER_AXIS - 1))
      else $error("group count ran past the group size");

   a_y_clears_x: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && group_axis_ff) |=> (held_status_ff == tmf_pkg::XS_NONE))
      else $error("held X status survived a Y group");
`endif

endmodule
